[src/lfsc_pkg.sv]
// Shared types and constants of the length-framed sum-check receiver.
// No dependencies; every other file of the block but lfsc_chan_if imports this package.
package lfsc_pkg;

	// Frame layout
	localparam logic [7:0] MARK_BYTE    = 8'h40;
	localparam int         LEN_EXTRA    = 30;
	localparam int         LEN_HIGH_IDX = 25;
	localparam int         LEN_LOW_IDX  = 24;
	localparam int         TAIL_BYTES   = 3;
	localparam int         HDR2_IDX     = 1;
	localparam int         SER_LO_IDX   = 2;
	localparam int         SER_HI_IDX   = 3;
	localparam int         CMD_IDX      = 26;
	localparam int         TYPE_IDX     = 27;
	localparam int         COUNT_IDX    = 28;
	localparam int         SUM_START    = 5;

	localparam int MAX_FRAME_DEF = 1024;
	localparam int EXP_W         = 17;
	localparam int LEN_W         = 11;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_DATA    = 3'd1,
		ST_BAD_HEADER = 3'd2,
		ST_BAD_SUM    = 3'd3,
		ST_TOO_SHORT  = 3'd4
	} status_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] frame_length;
		logic [15:0]      serial_number;
		logic             repeated;
		logic [7:0]       command_byte;
		logic [7:0]       info_type;
		logic [7:0]       object_count;
	} out_item_t;

endpackage

[src/lfsc_chan_if.sv]
// Valid/ready channel carrying one item of a payload type.
// Used with lfsc_pkg::in_item_t and lfsc_pkg::out_item_t.
interface lfsc_chan_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[src/lfsc_frame_track.sv]
// Frame state and end-of-frame checks: one item is processed per step.
// Depends on lfsc_pkg.
module lfsc_frame_track #(
	parameter int MAX_FRAME = lfsc_pkg::MAX_FRAME_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  lfsc_pkg::in_item_t  item,
	output logic                emit,
	output lfsc_pkg::out_item_t result
);
	import lfsc_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	logic             in_frame_q, in_frame_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [7:0]       sum_q, sum_n;
	logic [7:0]       rec_q [3];
	logic [7:0]       rec_n [3];
	logic [7:0]       len_lo_q, len_lo_n;
	logic [EXP_W-1:0] exp_q, exp_n;
	logic             hdr_ok_q, hdr_ok_n;
	logic [15:0]      serial_q, serial_n;
	logic [7:0]       cmd_q, cmd_n;
	logic [7:0]       typ_q, typ_n;
	logic [7:0]       objs_q, objs_n;
	logic [15:0]      prev_q, prev_n;
	logic             close;
	logic [CNT_W-1:0] idx;
	status_t          st;

	function automatic status_t check(input logic [CNT_W-1:0] n, input logic ok2,
			input logic [7:0] sum, input logic [7:0] r0);
		status_t s;
		if (n == '0) s = ST_NO_DATA;
		else if (n <= CNT_W'(TAIL_BYTES)) s = ST_TOO_SHORT;
		else if (!ok2) s = ST_BAD_HEADER;
		else if (sum != r0) s = ST_BAD_SUM;
		else s = ST_OK;
		return s;
	endfunction

	// Outside a frame all frame state is zero, so a start byte needs no clear.
	always_comb begin
		in_frame_n = in_frame_q;
		cnt_n      = cnt_q;
		sum_n      = sum_q;
		rec_n      = rec_q;
		len_lo_n   = len_lo_q;
		exp_n      = exp_q;
		hdr_ok_n   = hdr_ok_q;
		serial_n   = serial_q;
		cmd_n      = cmd_q;
		typ_n      = typ_q;
		objs_n     = objs_q;
		prev_n     = prev_q;
		close      = 1'b0;
		idx        = cnt_q;
		if (item.action) begin
			close = 1'b1;
		end else if (in_frame_q || item.rx_byte == MARK_BYTE) begin
			in_frame_n = 1'b1;
			if (idx >= CNT_W'(SUM_START)) sum_n = sum_q + rec_q[0];
			rec_n[0] = rec_q[1];
			rec_n[1] = rec_q[2];
			rec_n[2] = item.rx_byte;
			case (idx)
				CNT_W'(HDR2_IDX):     hdr_ok_n = (item.rx_byte == MARK_BYTE);
				CNT_W'(SER_LO_IDX):   serial_n[7:0] = item.rx_byte;
				CNT_W'(SER_HI_IDX):   serial_n[15:8] = item.rx_byte;
				CNT_W'(LEN_LOW_IDX):  len_lo_n = item.rx_byte;
				CNT_W'(LEN_HIGH_IDX): exp_n = EXP_W'(len_lo_q) + {1'b0, item.rx_byte, 8'h00}
						+ EXP_W'(LEN_EXTRA);
				CNT_W'(CMD_IDX):      cmd_n = item.rx_byte;
				CNT_W'(TYPE_IDX):     typ_n = item.rx_byte;
				CNT_W'(COUNT_IDX):    objs_n = item.rx_byte;
				default: ;
			endcase
			cnt_n = idx + 1'b1;
			close = (cnt_n > CNT_W'(LEN_HIGH_IDX)) &&
				((EXP_W'(cnt_n) >= exp_n) || (cnt_n >= CNT_W'(MAX_FRAME)));
		end

		st                   = check(cnt_n, hdr_ok_n, sum_n, rec_n[0]);
		result.status        = st;
		result.frame_length  = LEN_W'(cnt_n);
		result.serial_number = serial_n;
		result.repeated      = (st == ST_OK) && (serial_n == prev_q);
		result.command_byte  = cmd_n;
		result.info_type     = typ_n;
		result.object_count  = objs_n;
		emit                 = close;

		if (close) begin
			if (st == ST_OK) prev_n = serial_n;
			in_frame_n = 1'b0;
			cnt_n      = '0;
			sum_n      = '0;
			rec_n[0]   = '0;
			rec_n[1]   = '0;
			rec_n[2]   = '0;
			len_lo_n   = '0;
			exp_n      = '0;
			hdr_ok_n   = 1'b0;
			serial_n   = '0;
			cmd_n      = '0;
			typ_n      = '0;
			objs_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			sum_q      <= '0;
			rec_q[0]   <= '0;
			rec_q[1]   <= '0;
			rec_q[2]   <= '0;
			len_lo_q   <= '0;
			exp_q      <= '0;
			hdr_ok_q   <= 1'b0;
			serial_q   <= '0;
			cmd_q      <= '0;
			typ_q      <= '0;
			objs_q     <= '0;
			prev_q     <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_n;
			cnt_q      <= cnt_n;
			sum_q      <= sum_n;
			rec_q      <= rec_n;
			len_lo_q   <= len_lo_n;
			exp_q      <= exp_n;
			hdr_ok_q   <= hdr_ok_n;
			serial_q   <= serial_n;
			cmd_q      <= cmd_n;
			typ_q      <= typ_n;
			objs_q     <= objs_n;
			prev_q     <= prev_n;
		end
	end

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(MAX_FRAME))
		else $error("byte count reached the frame limit without closing");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (cnt_q == '0 && sum_q == '0 && serial_q == '0 && exp_q == '0))
		else $error("frame state not cleared outside a frame");

	a_timeout_emits: assert property (@(posedge clk) disable iff (!arst_n)
		item.action |-> emit)
		else $error("timeout did not produce a result");

endmodule

[src/lfsc_result_reg.sv]
// Output holding register: one result waits here until the sink takes it.
// Depends on lfsc_pkg and lfsc_chan_if.
module lfsc_result_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  lfsc_pkg::out_item_t data_in,
	output logic                free,
	lfsc_chan_if.source         out_ch
);
	import lfsc_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign free         = !valid_q || out_ch.ready;
	assign out_ch.valid = valid_q;
	assign out_ch.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) data_q <= data_in;
	end

endmodule

[src/length_framed_sum_check_receiver.sv]
// Length-framed sum-check receiver: top level.
// Depends on lfsc_pkg, lfsc_chan_if, lfsc_frame_track and lfsc_result_reg.
//
// The block takes one item per cycle on in_ch: a received serial byte
// (action 0) or a receive timeout (action 1). Bytes are dropped until an
// '@' opens a frame; from then on every byte is counted. Once byte 25 has
// arrived the frame length is the little-endian word at bytes 24..25 plus
// 30, and the frame closes at that length, at MAX_FRAME bytes, or on a
// timeout. Each close (and each timeout, even outside a frame) gives one
// result on out_ch with a status (ok, no data, bad header, bad checksum,
// too short), the byte count, the serial number from bytes 2..3, a flag
// for a serial repeated from the previous good frame, and bytes 26..28.
// The checksum is the 8-bit sum of bytes 2..n-4 compared against byte n-3.
// Throughput is one item per cycle while nothing stalls: an item waits in
// the input register, where the frame tracker updates its state in a
// single pass, and its result (if any) lands in the output register the
// same edge. Each result passes the input and then the output register.
// Only a result that finds the output register still full holds the
// input register; bytes that produce no result always advance.
module length_framed_sum_check_receiver #(
	parameter int MAX_FRAME = lfsc_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lfsc_chan_if.sink   in_ch,
	lfsc_chan_if.source out_ch
);
	import lfsc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      emit;
	logic      free;
	logic      step;
	out_item_t result;

	// Advance the held item unless it has a result and the output is full.
	assign step        = valid_s1 && (!emit || free);
	assign in_ch.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Payload of the input register: capture on accept only.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) item_s1 <= in_ch.data;
	end

	lfsc_frame_track #(
		.MAX_FRAME (MAX_FRAME)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.emit   (emit),
		.result (result)
	);

	lfsc_result_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step && emit),
		.data_in (result),
		.free    (free),
		.out_ch  (out_ch)
	);

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled item in the input register was lost");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(step && emit))
		else $error("result appeared without a closing item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
		else $error("pending result was overwritten");

endmodule
